### rtl/gkps_pkg.sv
// Shared types, codes and constants for the Gaussian kernel pair sum block.
// No dependencies; imported by the engine and the top level.
package gkps_pkg;

    // Request codes carried by req_type
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_COMPARE = 2'd1;
    localparam logic [1:0] REQ_READOUT = 2'd2;

    // Kernel modes held in exp_mode
    localparam logic [1:0] MODE_EXACT    = 2'd0;
    localparam logic [1:0] MODE_SQUARING = 2'd1;
    localparam logic [1:0] MODE_DIST     = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_SIGMA = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXP_MODE  = 2'd1;

    localparam logic [31:0] INV_SIGMA_RESET = 32'h0001_0000;
    localparam int unsigned MAX_REFERENCES_DEFAULT = 1024;

    // Series and squaring counts
    localparam logic [4:0] SERIES_LAST = 5'd16;
    localparam logic [3:0] SQUARE_LAST = 4'd9;
    localparam logic [4:0] EXP_STEPS_MAX = 5'd24;

    // Engine status toward the sequencer
    typedef struct packed {
        logic ready;
        logic done;
        logic sat;
    } eng_status_t;

    // ceil(2^40 / i) for i = 1..16; floor(x * R >> 40) equals floor(x / i) for x < 2^36
    function automatic logic [63:0] recip_lookup(input logic [4:0] i);
        logic [63:0] r;
        begin
            r = 64'd0;
            case (i)
                5'd1:    r = 64'd1099511627776;
                5'd2:    r = 64'd549755813888;
                5'd3:    r = 64'd366503875926;
                5'd4:    r = 64'd274877906944;
                5'd5:    r = 64'd219902325556;
                5'd6:    r = 64'd183251937963;
                5'd7:    r = 64'd157073089683;
                5'd8:    r = 64'd137438953472;
                5'd9:    r = 64'd122167958642;
                5'd10:   r = 64'd109951162778;
                5'd11:   r = 64'd99955602526;
                5'd12:   r = 64'd91625968982;
                5'd13:   r = 64'd84577817522;
                5'd14:   r = 64'd78536544842;
                5'd15:   r = 64'd73300775186;
                5'd16:   r = 64'd68719476736;
                default: r = 64'd0;
            endcase
            return r;
        end
    endfunction

endpackage

### rtl/gaussian_kernel_pair_sum.sv
// Top level of the Gaussian kernel pair sum: handshakes, config, reference store, sum.
// Depends on gkps_pkg, gkps_ram and gkps_engine.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  in      | input     | in_valid/in_stall   | req_type, sample
//  out     | output    | out_valid/out_stall | kernel_sum, sum_saturated, store_overflow
//  cfg     | input     | cfg_write           | cfg_index, cfg_data
//
// Load and readout words are handled in the idle state. A compare word walks the stored
// references one at a time: per entry a store read (S_RD), an engine start (S_GO) and a
// wait for the term (S_TERM). The term engine's 64x64 multiplies share one 32x32 multiplier.
// After reset the engine first computes its exp(-1) constant; in_stall is high meanwhile.
// in_stall stays high while a compare runs or a readout word waits for the consumer.
module gaussian_kernel_pair_sum
    import gkps_pkg::*;
#(
    parameter int unsigned MAX_REFERENCES = MAX_REFERENCES_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             req_type,
    input  logic signed [31:0]     sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [63:0]            kernel_sum,
    output logic                   sum_saturated,
    output logic                   store_overflow,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    localparam int unsigned AW = (MAX_REFERENCES > 1) ? $clog2(MAX_REFERENCES) : 1;
    localparam int unsigned CW = $clog2(MAX_REFERENCES + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_REFERENCES);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_GO   = 4'b0100,
        S_TERM = 4'b1000
    } seq_state_t;

    seq_state_t         st_reg, st_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [63:0]        sum_reg, sum_next;
    logic               sat_reg, sat_next;
    logic               ovf_reg, ovf_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        inv_sigma_reg;
    logic [1:0]         exp_mode_reg;
    logic signed [31:0] y_reg, y_next;
    logic [63:0]        out_sum_reg, out_sum_next;
    logic               out_sat_reg, out_sat_next;
    logic               out_ovf_reg, out_ovf_next;

    logic               in_take;
    logic               ram_we;
    logic [31:0]        ram_q;
    logic               eng_start;
    eng_status_t        eng_status;
    logic [63:0]        eng_term;
    logic signed [32:0] diff;
    logic [64:0]        sum_add;

    gkps_ram #(
        .WIDTH (32),
        .DEPTH (MAX_REFERENCES),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (sample),
        .re    (st_reg == S_RD),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_q)
    );

    gkps_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (eng_start),
        .diff      (diff),
        .mode      (exp_mode_reg),
        .inv_sigma (inv_sigma_reg),
        .status    (eng_status),
        .term      (eng_term)
    );

    // Accept a word only when idle, with the engine ready and the result slot free
    assign in_stall  = !((st_reg == S_IDLE) && eng_status.ready && !out_valid_reg);
    assign in_take   = in_valid && !in_stall;
    assign ram_we    = in_take && (req_type == REQ_LOAD) && (count_reg < COUNT_MAX);
    assign eng_start = (st_reg == S_GO);
    assign diff      = 33'(y_reg) - 33'(signed'(ram_q));
    assign sum_add   = {1'b0, sum_reg} + {1'b0, eng_term};

    // Sequence loads, compares and readouts
    always_comb
    begin
        st_next        = st_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        sat_next       = sat_reg;
        ovf_next       = ovf_reg;
        y_next         = y_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_sum_next   = out_sum_reg;
        out_sat_next   = out_sat_reg;
        out_ovf_next   = out_ovf_reg;

        unique case (st_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    case (req_type)
                        REQ_LOAD:
                        begin
                            if (count_reg < COUNT_MAX)
                            begin
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        REQ_COMPARE:
                        begin
                            y_next   = sample;
                            idx_next = '0;
                            if (count_reg != '0)
                            begin
                                st_next = S_RD;
                            end
                        end
                        REQ_READOUT:
                        begin
                            out_valid_next = 1'b1;
                            out_sum_next   = sum_reg;
                            out_sat_next   = sat_reg;
                            out_ovf_next   = ovf_reg;
                            sum_next       = 64'd0;
                            count_next     = '0;
                            sat_next       = 1'b0;
                            ovf_next       = 1'b0;
                        end
                        default:
                        begin
                            st_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                st_next = S_GO;
            end
            S_GO:
            begin
                st_next = S_TERM;
            end
            S_TERM:
            begin
                // Add the term with saturation, then advance to the next entry or return to idle after the last
                if (eng_status.done)
                begin
                    if (eng_status.sat)
                    begin
                        sat_next = 1'b1;
                    end
                    if (sum_add[64])
                    begin
                        sum_next = '1;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        sum_next = sum_add[63:0];
                    end
                    idx_next = idx_reg + CW'(1);
                    st_next  = ((idx_reg + CW'(1)) == count_reg) ? S_IDLE : S_RD;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            sum_reg       <= 64'd0;
            sat_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            inv_sigma_reg <= INV_SIGMA_RESET;
            exp_mode_reg  <= MODE_EXACT;
        end
        else
        begin
            st_reg        <= st_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            sat_reg       <= sat_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_INV_SIGMA: inv_sigma_reg <= cfg_data;
                    CFG_EXP_MODE:  exp_mode_reg  <= cfg_data[1:0];
                    default:       exp_mode_reg  <= exp_mode_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        y_reg       <= y_next;
        out_sum_reg <= out_sum_next;
        out_sat_reg <= out_sat_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign out_valid      = out_valid_reg;
    assign kernel_sum     = out_sum_reg;
    assign sum_saturated  = out_sat_reg;
    assign store_overflow = out_ovf_reg;

    // A pending result word blocks new input words
    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> in_stall)
        else $error("input taken while a result word waits");

    // The store walk never reads at or past the fill count
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_RD) |-> (idx_reg < count_reg))
        else $error("store read beyond fill count");

    // The engine is started only when it is free
    a_engine_free: assert property (@(posedge clk) disable iff (!rst_n)
        eng_start |-> eng_status.ready)
        else $error("term engine started while busy");

    // A term finishes only while the sequencer waits for it
    a_done_in_term: assert property (@(posedge clk) disable iff (!rst_n)
        eng_status.done |-> (st_reg == S_TERM))
        else $error("term done outside a store walk");

endmodule

### rtl/gkps_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module gkps_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/gkps_mul.sv
// 64 x 64 -> 128 multiplier built from four partial products of one 32 x 32 multiplier.
// No dependencies; result word is valid in the cycle done is high.
module gkps_mul (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [63:0]   a,
    input  logic [63:0]   b,
    output logic          done,
    output logic [127:0]  p
);

    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic         pv_reg;
    logic         done_reg;
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [63:0]  prod_reg;
    logic [1:0]   sh_reg;
    logic [127:0] acc_reg;

    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [63:0]  product;
    logic [1:0]   sh;
    logic [127:0] acc_add;

    // Select halves: step 0 lo*lo, 1 lo*hi, 2 hi*lo, 3 hi*hi
    always_comb
    begin
        a_half  = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        b_half  = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        product = 64'(a_half) * 64'(b_half);
        sh      = 2'(cnt_reg[1]) + 2'(cnt_reg[0]);
        acc_add = acc_reg + ({64'd0, prod_reg} << {sh_reg, 5'd0});
    end

    // Sequence the four partial products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 3'd0;
            busy_reg <= 1'b0;
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= 3'd0;
                busy_reg <= 1'b1;
                pv_reg   <= 1'b0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg != 3'd4)
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    pv_reg  <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b0;
                    pv_reg   <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands, partial product and accumulator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= 128'd0;
        end
        else if (pv_reg)
        begin
            acc_reg <= acc_add;
        end
        prod_reg <= product;
        sh_reg   <= sh;
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

### rtl/gkps_engine.sv
// Kernel term engine: computes one term from a sample difference in the selected mode.
// Depends on gkps_pkg and gkps_mul; computes the exp(-1) constant once after reset.
module gkps_engine
    import gkps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [32:0] diff,
    input  logic [1:0]         mode,
    input  logic [31:0]        inv_sigma,
    output eng_status_t        status,
    output logic [63:0]        term
);

    typedef enum logic [7:0] {
        E_INIT = 8'b0000_0001,
        E_IDLE = 8'b0000_0010,
        E_B    = 8'b0000_0100,
        E_P    = 8'b0000_1000,
        E_SM   = 8'b0001_0000,
        E_SD   = 8'b0010_0000,
        E_EM   = 8'b0100_0000,
        E_SQ   = 8'b1000_0000
    } eng_state_t;

    eng_state_t  st_reg, st_next;
    logic        go_reg, go_next;
    logic        init_reg, init_next;
    logic        done_reg, done_next;
    logic        sat_reg, sat_next;
    logic [1:0]  mode_reg, mode_next;
    logic [4:0]  i_reg, i_next;
    logic [4:0]  n_reg, n_next;
    logic [3:0]  k_reg, k_next;
    logic [63:0] op_a_reg, op_a_next;
    logic [63:0] op_b_reg, op_b_next;
    logic [24:0] f_reg, f_next;
    logic [63:0] t_reg, t_next;
    logic [63:0] s_reg, s_next;
    logic [63:0] e1_reg, e1_next;
    logic [63:0] term_reg, term_next;

    logic         mul_done;
    logic [127:0] p;
    logic [32:0]  mag;
    logic [63:0]  c;
    logic [63:0]  t_new;
    logic [63:0] s_new;
    logic [63:0]  r_new;
    logic [39:0]  n_full;

    gkps_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (go_reg),
        .a     (op_a_reg),
        .b     (op_b_reg),
        .done  (mul_done),
        .p     (p)
    );

    // Sequence the term computation
    always_comb
    begin
        st_next   = st_reg;
        go_next   = 1'b0;
        init_next = init_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        mode_next = mode_reg;
        i_next    = i_reg;
        n_next    = n_reg;
        k_next    = k_reg;
        op_a_next = op_a_reg;
        op_b_next = op_b_reg;
        f_next    = f_reg;
        t_next    = t_reg;
        s_next    = s_reg;
        e1_next   = e1_reg;
        term_next = term_reg;

        mag    = diff[32] ? (33'd0 - 33'(diff)) : 33'(diff);
        c      = p[104:41];
        n_full = p[104:65];
        t_new  = p[103:40];
        s_new  = i_reg[0] ? (s_reg - t_new) : (s_reg + t_new);
        r_new  = p[95:32];

        unique case (st_reg)
            E_INIT:
            begin
                // Series of exp(-1) for the integer steps
                f_next    = 25'h100_0000;
                t_next    = 64'h1_0000_0000;
                s_next    = 64'h1_0000_0000;
                i_next    = 5'd1;
                n_next    = 5'd0;
                op_a_next = 64'h1_0000_0000;
                op_b_next = 64'h100_0000;
                go_next   = 1'b1;
                st_next   = E_SM;
            end
            E_IDLE:
            begin
                if (start)
                begin
                    mode_next = mode;
                    sat_next  = 1'b0;
                    if (mode == 2'd3)
                    begin
                        term_next = 64'd0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        op_a_next = {32'd0, mag[31:0]};
                        op_b_next = {32'd0, inv_sigma};
                        go_next   = 1'b1;
                        st_next   = E_B;
                    end
                end
            end
            E_B:
            begin
                if (mul_done)
                begin
                    op_a_next = p[63:0];
                    op_b_next = p[63:0];
                    go_next   = 1'b1;
                    st_next   = E_P;
                end
            end
            E_P:
            begin
                if (mul_done)
                begin
                    st_next = E_IDLE;
                    case (mode_reg)
                        MODE_DIST:
                        begin
                            done_next = 1'b1;
                            if (|p[127:104])
                            begin
                                sat_next  = 1'b1;
                                term_next = '1;
                            end
                            else
                            begin
                                term_next = p[103:40];
                            end
                        end
                        MODE_EXACT:
                        begin
                            if ((|p[127:105]) || (|n_full[39:5]) ||
                                (n_full[4:0] >= EXP_STEPS_MAX))
                            begin
                                term_next = 64'd0;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                n_next    = n_full[4:0];
                                f_next    = {1'b0, c[23:0]};
                                t_next    = 64'h1_0000_0000;
                                s_next    = 64'h1_0000_0000;
                                i_next    = 5'd1;
                                op_a_next = 64'h1_0000_0000;
                                op_b_next = {40'd0, c[23:0]};
                                go_next   = 1'b1;
                                st_next   = E_SM;
                            end
                        end
                        default:
                        begin
                            if (|p[127:105])
                            begin
                                sat_next  = 1'b1;
                                term_next = '1;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                op_a_next = (c <= 64'h4_0000_0000) ?
                                            (64'h4_0000_0000 - c) : (c - 64'h4_0000_0000);
                                op_b_next = op_a_next;
                                k_next    = 4'd0;
                                go_next   = 1'b1;
                                st_next   = E_SQ;
                            end
                        end
                    endcase
                end
            end
            E_SM:
            begin
                // Scale the previous series term by f, then divide by the index
                if (mul_done)
                begin
                    op_a_next = p[87:24];
                    op_b_next = recip_lookup(i_reg);
                    go_next   = 1'b1;
                    st_next   = E_SD;
                end
            end
            E_SD:
            begin
                if (mul_done)
                begin
                    t_next = t_new;
                    s_next = s_new;
                    if (i_reg == SERIES_LAST)
                    begin
                        if (init_reg)
                        begin
                            e1_next   = s_new;
                            init_next = 1'b0;
                            st_next   = E_IDLE;
                        end
                        else if (n_reg == 5'd0)
                        begin
                            term_next = (s_new + 64'd128) >> 8;
                            done_next = 1'b1;
                            st_next   = E_IDLE;
                        end
                        else
                        begin
                            op_a_next = s_new;
                            op_b_next = e1_reg;
                            go_next   = 1'b1;
                            st_next   = E_EM;
                        end
                    end
                    else
                    begin
                        i_next    = i_reg + 5'd1;
                        op_a_next = t_new;
                        op_b_next = {39'd0, f_reg};
                        go_next   = 1'b1;
                        st_next   = E_SM;
                    end
                end
            end
            E_EM:
            begin
                // Multiply by exp(-1) once per integer step
                if (mul_done)
                begin
                    if (n_reg == 5'd1)
                    begin
                        term_next = (r_new + 64'd128) >> 8;
                        done_next = 1'b1;
                        st_next   = E_IDLE;
                    end
                    else
                    begin
                        n_next    = n_reg - 5'd1;
                        op_a_next = r_new;
                        op_b_next = e1_reg;
                        go_next   = 1'b1;
                    end
                end
            end
            E_SQ:
            begin
                if (mul_done)
                begin
                    if (k_reg != SQUARE_LAST)
                    begin
                        if (|p[127:98])
                        begin
                            sat_next  = 1'b1;
                            term_next = '1;
                            done_next = 1'b1;
                            st_next   = E_IDLE;
                        end
                        else
                        begin
                            k_next    = k_reg + 4'd1;
                            op_a_next = p[97:34];
                            op_b_next = p[97:34];
                            go_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        done_next = 1'b1;
                        st_next   = E_IDLE;
                        if (|p[127:108])
                        begin
                            sat_next  = 1'b1;
                            term_next = '1;
                        end
                        else
                        begin
                            term_next = p[107:44];
                        end
                    end
                end
            end
            default:
            begin
                st_next = E_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= E_INIT;
            go_reg   <= 1'b0;
            init_reg <= 1'b1;
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            go_reg   <= go_next;
            init_reg <= init_next;
            done_reg <= done_next;
            sat_reg  <= sat_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        i_reg    <= i_next;
        n_reg    <= n_next;
        k_reg    <= k_next;
        op_a_reg <= op_a_next;
        op_b_reg <= op_b_next;
        f_reg    <= f_next;
        t_reg    <= t_next;
        s_reg    <= s_next;
        e1_reg   <= e1_next;
        term_reg <= term_next;
    end

    assign status.ready = (st_reg == E_IDLE) && !done_reg;
    assign status.done  = done_reg;
    assign status.sat   = sat_reg;
    assign term         = term_reg;

endmodule

### sim/gaussian_kernel_pair_sum_tb.sv
// Self-checking testbench for gaussian_kernel_pair_sum: bit-exact kernel sum scoreboard,
// bursty word source, patterned result stall. Depends on gkps_pkg and the RTL top level.
module gaussian_kernel_pair_sum_tb;
    import gkps_pkg::*;

    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam logic [1:0] MODE_ZERO = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int STORE_DEPTH = 1024;
    localparam int IDLE_LIMIT = 1500000;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // Kernel sum scoreboard: own copy of block state, queue of pending readouts
    class kernel_sum_board;
        logic signed [31:0] refs [STORE_DEPTH];
        int unsigned ref_count;
        logic [63:0] sum_acc;
        bit sat_flag;
        bit ovf_flag;
        logic [31:0] inv_sigma;
        logic [1:0] exp_mode;
        logic [65:0] readout_q [$];
        int errors;
        int words;
        int readouts;

        function void clear_all();
            ref_count = 0;
            sum_acc = 0;
            sat_flag = 0;
            ovf_flag = 0;
            inv_sigma = INV_SIGMA_RESET;
            exp_mode = MODE_EXACT;
            readout_q.delete();
            errors = 0;
            words = 0;
            readouts = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
            if (idx == CFG_INV_SIGMA)
                inv_sigma = data;
            else if (idx == CFG_EXP_MODE)
                exp_mode = data[1:0];
        endfunction

        // exp(-f), f in Q.24, result in Q.32, degree-16 series
        function logic [63:0] exp_series(logic [63:0] f);
            logic [63:0] t;
            logic [63:0] s;
            t = 64'd1 << 32;
            s = 64'd1 << 32;
            for (int i = 1; i <= 16; i++)
            begin
                t = ((t * f) >> 24) / i;
                if (i % 2 == 1)
                    s = s - t;
                else
                    s = s + t;
            end
            return s;
        endfunction

        function logic [63:0] kernel_term(longint d, output bit hit);
            logic [63:0] mag;
            logic [127:0] b;
            logic [127:0] p;
            logic [127:0] w;
            logic [127:0] mm;
            logic [63:0] c;
            logic [63:0] r;
            logic [63:0] e1;
            logic [63:0] n;
            hit = 0;
            mag = (d < 0) ? -d : d;
            b = mag * {32'd0, inv_sigma};
            b[127:64] = 0;
            p = b * b;
            if (exp_mode == MODE_DIST)
            begin
                w = p >> 40;
                if (w[127:64] != 0)
                begin
                    hit = 1;
                    return ALL_ONES;
                end
                return w[63:0];
            end
            if (exp_mode == MODE_ZERO)
                return 0;
            w = p >> 41;
            c = w[63:0];
            if (exp_mode == MODE_EXACT)
            begin
                if (w[127:64] != 0)
                    return 0;
                n = c >> 24;
                if (n >= 24)
                    return 0;
                e1 = exp_series(64'd1 << 24);
                r = exp_series({40'd0, c[23:0]});
                for (int k = 0; k < n; k++)
                    r = (r * e1) >> 32;
                return (r + 128) >> 8;
            end
            // repeated squaring of |1 - c| in Q.34
            if (w[127:64] != 0)
            begin
                hit = 1;
                return ALL_ONES;
            end
            mm = (c <= (64'd1 << 34)) ? (64'd1 << 34) - c : c - (64'd1 << 34);
            for (int k = 0; k < 9; k++)
            begin
                w = (mm * mm) >> 34;
                if (w[127:64] != 0)
                begin
                    hit = 1;
                    return ALL_ONES;
                end
                mm = {64'd0, w[63:0]};
            end
            w = (mm * mm) >> 44;
            if (w[127:64] != 0)
            begin
                hit = 1;
                return ALL_ONES;
            end
            return w[63:0];
        endfunction

        // Note one accepted input word and advance the state
        function void note_word(logic [1:0] req, logic signed [31:0] smp);
            logic [63:0] t;
            logic [63:0] s;
            bit hit;
            words++;
            case (req)
                REQ_LOAD:
                begin
                    if (ref_count < STORE_DEPTH)
                    begin
                        refs[ref_count] = smp;
                        ref_count++;
                    end
                    else
                        ovf_flag = 1;
                end
                REQ_COMPARE:
                begin
                    for (int i = 0; i < ref_count; i++)
                    begin
                        t = kernel_term(longint'(smp) - longint'(refs[i]), hit);
                        if (hit)
                            sat_flag = 1;
                        s = sum_acc + t;
                        if (s < t)
                        begin
                            s = ALL_ONES;
                            sat_flag = 1;
                        end
                        sum_acc = s;
                    end
                end
                REQ_READOUT:
                begin
                    readout_q.push_back({sum_acc, sat_flag, ovf_flag});
                    sum_acc = 0;
                    ref_count = 0;
                    sat_flag = 0;
                    ovf_flag = 0;
                end
                default: ;
            endcase
        endfunction

        // Check one accepted result against the oldest pending readout
        function void check_result(logic [63:0] ks, logic sat, logic ovf);
            logic [65:0] exp_word;
            readouts++;
            if (readout_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("MISMATCH: unexpected result sum=%h sat=%b ovf=%b", ks, sat, ovf);
                return;
            end
            exp_word = readout_q.pop_front();
            if (exp_word !== {ks, sat, ovf})
            begin
                errors++;
                if (errors <= 10)
                    $display("MISMATCH: sum exp %h got %h, sat exp %b got %b, ovf exp %b got %b",
                             exp_word[65:2], ks, exp_word[1], sat, exp_word[0], ovf);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] req_type;
    logic signed [31:0] sample;
    logic out_valid;
    logic out_stall;
    logic [63:0] kernel_sum;
    logic sum_saturated;
    logic store_overflow;
    logic cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    kernel_sum_board board;
    int burst_left;
    int idle_cycles;
    int stall_cnt;
    int stall_mode;
    int phases;

    gaussian_kernel_pair_sum dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .sample(sample),
        .out_valid(out_valid), .out_stall(out_stall),
        .kernel_sum(kernel_sum), .sum_saturated(sum_saturated),
        .store_overflow(store_overflow),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Check results; stall the output on a shifting pattern
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(kernel_sum, sum_saturated, store_overflow);
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 96 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            1: out_stall <= ($urandom_range(0, 1) == 1);
            2: out_stall <= (stall_cnt % 16 < 11);
            3: out_stall <= ($urandom_range(0, 7) == 0);
            default: out_stall <= 1'b0;
        endcase
    end

    // Watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Drive one word, leaving valid high; insert burst gaps before it
    task automatic send_word(logic [1:0] req, logic signed [31:0] smp);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        req_type <= req;
        sample <= smp;
        do
            @(posedge clk);
        while (in_stall);
        board.note_word(req, smp);
    endtask

    // Hold off until every readout has come back, then let the engine settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.readout_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        board.write_reg(idx, data);
    endtask

    task automatic set_config(logic [31:0] sigma, logic [1:0] mode);
        write_reg(CFG_INV_SIGMA, sigma);
        write_reg(CFG_EXP_MODE, {$urandom_range(0, 1) == 1 ? 30'h3FFF_FFFF : 30'd0, mode});
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] near(logic signed [31:0] base, int spread);
        return base + $signed($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // One phase: loads around a center, compares nearby, noise, then a readout
    task automatic run_phase();
        logic signed [31:0] center;
        int spread;
        int n_load;
        int n_cmp;
        center = $urandom;
        spread = ($urandom_range(0, 3) == 0) ? 32'h7FFF_FFFF : $urandom_range(1, 1 << 18);
        n_load = $urandom_range(0, 8);
        n_cmp = $urandom_range(0, 4);
        for (int i = 0; i < n_load; i++)
            send_word(REQ_LOAD, near(center, spread));
        for (int i = 0; i < n_cmp; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_word(REQ_NONE, $urandom);
            send_word(REQ_COMPARE, near(center, spread));
            if ($urandom_range(0, 7) == 0)
                send_word(REQ_LOAD, near(center, spread));
        end
        send_word(REQ_READOUT, $urandom);
    endtask

    initial
    begin
        logic [31:0] sigma;
        board = new();
        board.clear_all();
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_LOAD;
        sample = '0;
        out_stall = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_INV_SIGMA;
        cfg_data = '0;
        burst_left = 0;
        idle_cycles = 0;
        stall_cnt = 0;
        stall_mode = 0;
        phases = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes under reset settings, empty store, ignored code
        send_word(REQ_LOAD, 32'sd0);
        send_word(REQ_LOAD, 32'sh7FFF_FFFF);
        send_word(REQ_LOAD, 32'sh8000_0000);
        send_word(REQ_LOAD, -32'sd1);
        send_word(REQ_COMPARE, 32'sd0);
        send_word(REQ_COMPARE, 32'sh7FFF_FFFF);
        send_word(REQ_COMPARE, 32'sh8000_0000);
        send_word(REQ_NONE, 32'sh5555_5555);
        send_word(REQ_READOUT, 32'shAAAA_AAAA);
        send_word(REQ_COMPARE, 32'sd12345);
        send_word(REQ_READOUT, 32'sd0);
        drain();

        // Each mode with extreme bandwidths, including saturating squared distance
        for (int mode = 0; mode < 4; mode++)
        begin
            for (int s = 0; s < 3; s++)
            begin
                sigma = (s == 0) ? 32'd0 : (s == 1) ? 32'hFFFF_FFFF : INV_SIGMA_RESET;
                set_config(sigma, mode[1:0]);
                send_word(REQ_LOAD, 32'sh8000_0000);
                send_word(REQ_LOAD, 32'sd65536);
                send_word(REQ_COMPARE, 32'sh7FFF_FFFF);
                send_word(REQ_COMPARE, 32'sd0);
                send_word(REQ_READOUT, 32'sd0);
                drain();
            end
        end

        // Random phases, reconfigured between them
        while (board.words < 580)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                drain();
                case ($urandom_range(0, 4))
                    0: sigma = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
                    1: sigma = $urandom;
                    2: sigma = $urandom_range(1 << 12, 1 << 20);
                    default: sigma = $urandom_range(1 << 14, 1 << 17);
                endcase
                set_config(sigma, $urandom_range(0, 3));
            end
            run_phase();
            phases++;
        end
        drain();

        $display("summary: %0d words, %0d readouts checked over %0d random phases",
                 board.words, board.readouts, phases);
        $display("summary: all kernel modes, bandwidth extremes, empty store, saturation");
        if (board.errors == 0 && board.readout_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
